/* sv/spi_mst_pkg.sv */
// Shared constants and types of the SPI byte transceiver.
`timescale 1ns / 1ps

package spi_mst_pkg;

   localparam int unsigned DATA_BITS  = 8;
   localparam int unsigned COUNT_BITS = 4;
   localparam int unsigned DIV_BITS   = 7;
   localparam int unsigned ADDR_BITS  = 5;
   localparam int unsigned CSR_BITS   = 32;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_ENABLE     = 3'd0;
   localparam logic [2:0] REG_MASTER     = 3'd1;
   localparam logic [2:0] REG_DIVIDE     = 3'd2;
   localparam logic [2:0] REG_POLARITY   = 3'd3;
   localparam logic [2:0] REG_PHASE      = 3'd4;
   localparam logic [2:0] REG_LOW_FIRST  = 3'd5;
   localparam logic [2:0] REG_IRQ_ENABLE = 3'd6;

   localparam logic [2:0] DIV_CODE_MAX   = 3'd6;
   localparam logic [2:0] DIV_CODE_RESET = 3'd1;

   typedef struct packed {
      logic       enable;
      logic       master_mode;
      logic [2:0] clock_divide_select;
      logic       clock_polarity;
      logic       clock_phase;
      logic       low_bit_first;
      logic       interrupt_enable;
   } cfg_type;

endpackage

/* sv/spi_master_slave_byte_transceiver.sv */
// SPI byte transceiver, master or slave, clock modes 0 to 3: top level.
//
//   channel | ports            | direction | moves
//   --------+------------------+-----------+-------------------------------------
//   req     | req_valid/ready  | in        | one system tick: load flag, byte, pins
//   rsp     | rsp_valid/ready  | out       | pin levels, received byte, done, busy, irq
//   csr     | psel .. pready   | in/out    | configuration registers, APB style
//
// The serial state of a request transaction is updated at acceptance and the
// result is held in one output register, so a request is taken in every cycle
// while the result register is empty or being drained. Results appear in the
// cycle after acceptance. A stalled result holds the request side only while
// the output register stays full. Reset is synchronous and clears all
// configuration and serial state; no clearing pass is needed.
`timescale 1ns / 1ps

module spi_master_slave_byte_transceiver (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [spi_mst_pkg::DATA_BITS-1:0]   req_tx_byte,
   input  logic                                req_miso_in,
   input  logic                                req_mosi_in,
   input  logic                                req_sck_in,
   input  logic                                req_select_n,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_sck_out,
   output logic                                rsp_mosi_out,
   output logic                                rsp_miso_out,
   output logic [spi_mst_pkg::DATA_BITS-1:0]   rsp_rx_byte,
   output logic                                rsp_done_res,
   output logic                                rsp_busy_res,
   output logic                                rsp_irq,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [spi_mst_pkg::ADDR_BITS-1:0]   paddr,
   input  logic [spi_mst_pkg::CSR_BITS-1:0]    pwdata,
   output logic [spi_mst_pkg::CSR_BITS-1:0]    prdata,
   output logic                                pready
);

   localparam int unsigned DW = spi_mst_pkg::DATA_BITS;
   localparam int unsigned CW = spi_mst_pkg::COUNT_BITS;
   localparam int unsigned VW = spi_mst_pkg::DIV_BITS;

   function automatic logic [DW-1:0] shift_in(input logic [DW-1:0] s, input logic b,
                                              input logic lsb);
      logic [DW-1:0] r;
      if (lsb) begin
         r = {b, s[DW-1:1]};
      end else begin
         r = {s[DW-2:0], b};
      end
      return r;
   endfunction

   spi_mst_pkg::cfg_type cfg_ff;

   logic [DW-1:0] shift_ff,   shift_in_v;
   logic [CW-1:0] count_ff,   count_in;
   logic [VW-1:0] div_ff,     div_in;
   logic          sck_ff,     sck_in_v;
   logic          prev_sck_ff;
   logic          busy_ff,    busy_in;
   logic [DW-1:0] rx_hold_ff, rx_hold_in;
   logic          sample_ff,  sample_in;

   logic          rsp_valid_ff;
   logic          sck_out_ff, mosi_out_ff, miso_out_ff, done_ff, busy_res_ff, irq_ff;
   logic [DW-1:0] rx_out_ff;

   logic          req_take;
   logic          csr_write;
   logic [2:0]    csr_index;
   logic          csr_bit;
   logic          abort_write;

   logic          done_in;
   logic          sck_o_in, mosi_o_in, miso_o_in;
   logic          edge_fire, edge_leading, edge_pin;
   logic [2:0]    div_code;
   logic [VW-1:0] div_half, div_next;

   assign pready      = 1'b1;
   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign req_take    = req_valid && req_ready;
   assign csr_write   = psel && penable && pwrite;
   assign csr_index   = paddr[4:2];
   assign csr_bit     = pwdata[0];
   // A changed enable or mode drops whatever transfer is under way.
   assign abort_write = csr_write &&
                        (((csr_index == spi_mst_pkg::REG_ENABLE) &&
                          (csr_bit != cfg_ff.enable)) ||
                         ((csr_index == spi_mst_pkg::REG_MASTER) &&
                          (csr_bit != cfg_ff.master_mode)));

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         spi_mst_pkg::REG_ENABLE:     prdata[0]   = cfg_ff.enable;
         spi_mst_pkg::REG_MASTER:     prdata[0]   = cfg_ff.master_mode;
         spi_mst_pkg::REG_DIVIDE:     prdata[2:0] = cfg_ff.clock_divide_select;
         spi_mst_pkg::REG_POLARITY:   prdata[0]   = cfg_ff.clock_polarity;
         spi_mst_pkg::REG_PHASE:      prdata[0]   = cfg_ff.clock_phase;
         spi_mst_pkg::REG_LOW_FIRST:  prdata[0]   = cfg_ff.low_bit_first;
         spi_mst_pkg::REG_IRQ_ENABLE: prdata[0]   = cfg_ff.interrupt_enable;
         default:                     prdata      = '0;
      endcase
   end

   assign div_code = (cfg_ff.clock_divide_select > spi_mst_pkg::DIV_CODE_MAX) ?
                     spi_mst_pkg::DIV_CODE_MAX : cfg_ff.clock_divide_select;
   assign div_half = VW'(1) << div_code;
   assign div_next = div_ff + VW'(1);

   always_comb begin
      shift_in_v   = shift_ff;
      count_in     = count_ff;
      div_in       = div_ff;
      sck_in_v     = sck_ff;
      busy_in      = busy_ff;
      rx_hold_in   = rx_hold_ff;
      sample_in    = sample_ff;
      done_in      = 1'b0;
      sck_o_in     = 1'b0;
      mosi_o_in    = 1'b0;
      miso_o_in    = 1'b0;
      edge_fire    = 1'b0;
      edge_leading = 1'b0;
      edge_pin     = 1'b0;

      // Mode-specific part: decide whether a serial clock edge happens.
      if (!cfg_ff.enable) begin
         busy_in  = 1'b0;
         count_in = '0;
         div_in   = '0;
         sck_in_v = cfg_ff.clock_polarity;
      end else if (cfg_ff.master_mode) begin
         if (!busy_ff) begin
            sck_in_v = cfg_ff.clock_polarity;
            div_in   = '0;
            if (req_kind) begin
               shift_in_v = req_tx_byte;
               busy_in    = 1'b1;
               count_in   = '0;
            end
         end else begin
            div_in = div_next;
            if (div_next >= div_half) begin
               div_in       = '0;
               sck_in_v     = !sck_ff;
               edge_fire    = 1'b1;
               edge_leading = (!sck_ff) != cfg_ff.clock_polarity;
               edge_pin     = req_miso_in;
            end
         end
      end else begin
         if (req_kind && !busy_ff) begin
            shift_in_v = req_tx_byte;
         end
         if (req_select_n) begin
            count_in = '0;
            busy_in  = 1'b0;
         end else if (req_sck_in != prev_sck_ff) begin
            busy_in      = 1'b1;
            edge_fire    = 1'b1;
            edge_leading = req_sck_in != cfg_ff.clock_polarity;
            edge_pin     = req_mosi_in;
         end
      end

      // Sample and shift on the serial clock edge, per clock phase.
      if (edge_fire) begin
         if (!cfg_ff.clock_phase) begin
            if (edge_leading) begin
               sample_in = edge_pin;
            end else begin
               shift_in_v = shift_in(shift_in_v, sample_in, cfg_ff.low_bit_first);
               count_in   = count_in + CW'(1);
            end
         end else begin
            if (edge_leading) begin
               if (count_in != '0) begin
                  shift_in_v = shift_in(shift_in_v, sample_in, cfg_ff.low_bit_first);
               end
            end else begin
               sample_in = edge_pin;
               count_in  = count_in + CW'(1);
               if (count_in >= CW'(DW)) begin
                  shift_in_v = shift_in(shift_in_v, sample_in, cfg_ff.low_bit_first);
               end
            end
         end
         if (count_in >= CW'(DW)) begin
            rx_hold_in = shift_in_v;
            count_in   = '0;
            div_in     = '0;
            busy_in    = 1'b0;
            done_in    = 1'b1;
         end
      end

      if (cfg_ff.enable && cfg_ff.master_mode) begin
         sck_o_in  = sck_in_v;
         mosi_o_in = cfg_ff.low_bit_first ? shift_in_v[0] : shift_in_v[DW-1];
      end else if (cfg_ff.enable && !req_select_n) begin
         miso_o_in = cfg_ff.low_bit_first ? shift_in_v[0] : shift_in_v[DW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable              <= 1'b0;
         cfg_ff.master_mode         <= 1'b0;
         cfg_ff.clock_divide_select <= spi_mst_pkg::DIV_CODE_RESET;
         cfg_ff.clock_polarity      <= 1'b0;
         cfg_ff.clock_phase         <= 1'b0;
         cfg_ff.low_bit_first       <= 1'b0;
         cfg_ff.interrupt_enable    <= 1'b0;
         shift_ff                   <= '0;
         count_ff                   <= '0;
         div_ff                     <= '0;
         sck_ff                     <= 1'b0;
         prev_sck_ff                <= 1'b0;
         busy_ff                    <= 1'b0;
         rx_hold_ff                 <= '0;
         sample_ff                  <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               spi_mst_pkg::REG_ENABLE:     cfg_ff.enable              <= csr_bit;
               spi_mst_pkg::REG_MASTER:     cfg_ff.master_mode         <= csr_bit;
               spi_mst_pkg::REG_DIVIDE:     cfg_ff.clock_divide_select <= pwdata[2:0];
               spi_mst_pkg::REG_POLARITY:   cfg_ff.clock_polarity      <= csr_bit;
               spi_mst_pkg::REG_PHASE:      cfg_ff.clock_phase         <= csr_bit;
               spi_mst_pkg::REG_LOW_FIRST:  cfg_ff.low_bit_first       <= csr_bit;
               spi_mst_pkg::REG_IRQ_ENABLE: cfg_ff.interrupt_enable    <= csr_bit;
               default: ;
            endcase
         end
         if (abort_write) begin
            busy_ff  <= 1'b0;
            count_ff <= '0;
            div_ff   <= '0;
            sck_ff   <= cfg_ff.clock_polarity;
         end else if (req_take) begin
            shift_ff    <= shift_in_v;
            count_ff    <= count_in;
            div_ff      <= div_in;
            sck_ff      <= sck_in_v;
            prev_sck_ff <= req_sck_in;
            busy_ff     <= busy_in;
            rx_hold_ff  <= rx_hold_in;
            sample_ff   <= sample_in;
         end
         if (req_take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         sck_out_ff  <= sck_o_in;
         mosi_out_ff <= mosi_o_in;
         miso_out_ff <= miso_o_in;
         rx_out_ff   <= rx_hold_in;
         done_ff     <= done_in;
         busy_res_ff <= busy_in;
         irq_ff      <= done_in && cfg_ff.interrupt_enable;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sck_out  = sck_out_ff;
   assign rsp_mosi_out = mosi_out_ff;
   assign rsp_miso_out = miso_out_ff;
   assign rsp_rx_byte  = rx_out_ff;
   assign rsp_done_res = done_ff;
   assign rsp_busy_res = busy_res_ff;
   assign rsp_irq      = irq_ff;

endmodule

/* tb/spi_master_slave_byte_transceiver_tb.sv */
// Self-checking testbench for the SPI byte transceiver: scripted ticks, then random phases.
`timescale 1ns / 1ps

module spi_master_slave_byte_transceiver_tb;

   localparam int unsigned ITEM_TARGET    = 950;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned SCRIPT_ROWS    = 26;
   localparam int unsigned DW             = spi_mst_pkg::DATA_BITS;
   localparam int unsigned CSR_W          = spi_mst_pkg::CSR_BITS;
   // Out-of-range divider select; the block treats it as the slowest divisor.
   localparam logic [2:0]  DIV_CODE_OVER  = 3'd7;

   typedef struct packed {
      logic          kind;
      logic [DW-1:0] tx;
      logic          miso;
      logic          mosi;
      logic          sck;
      logic          sel_n;
   } spi_tick_type;

   typedef struct packed {
      logic          sck_out;
      logic          mosi_out;
      logic          miso_out;
      logic [DW-1:0] rx;
      logic          done;
      logic          busy;
      logic          irq;
   } spi_view_type;

   typedef enum logic [1:0] {ROW_TICK, ROW_PINNED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type what;
      logic [2:0]   reg_idx;
      logic [2:0]   reg_value;
      spi_tick_type tick;
      spi_view_type pinned;
   } script_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic                                  req_kind;
   logic [DW-1:0]                         req_tx_byte;
   logic                                  req_miso_in;
   logic                                  req_mosi_in;
   logic                                  req_sck_in;
   logic                                  req_select_n;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic                                  rsp_sck_out;
   logic                                  rsp_mosi_out;
   logic                                  rsp_miso_out;
   logic [DW-1:0]                         rsp_rx_byte;
   logic                                  rsp_done_res;
   logic                                  rsp_busy_res;
   logic                                  rsp_irq;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [spi_mst_pkg::ADDR_BITS-1:0]     paddr;
   logic [CSR_W-1:0]                      pwdata;
   logic [CSR_W-1:0]                      prdata;
   logic                                  pready;

   // Mirror of the configuration and of the serial state of the block.
   spi_mst_pkg::cfg_type                  cfg_mirror;
   logic [DW-1:0]                         shift_q;
   logic [spi_mst_pkg::COUNT_BITS-1:0]    bits_q;
   logic [spi_mst_pkg::DIV_BITS-1:0]      div_q;
   logic                                  sck_q;
   logic                                  last_sck_q;
   logic                                  busy_q;
   logic [DW-1:0]                         rx_q;
   logic                                  sample_q;

   spi_view_type            awaited_views [$];
   int unsigned             mismatch_count = 0;
   int unsigned             sent_items = 0;
   int unsigned             idle_cycles = 0;

   spi_master_slave_byte_transceiver uut (.*);

   always #1 clock = ~clock;

   function automatic string show_view(spi_view_type v);
      return $sformatf("sck=%0b mosi=%0b miso=%0b rx=%02h done=%0b busy=%0b irq=%0b",
                       v.sck_out, v.mosi_out, v.miso_out, v.rx, v.done, v.busy, v.irq);
   endfunction

   function automatic void log_fault(string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   function automatic void abort_spi();
      busy_q = 1'b0;
      bits_q = '0;
      div_q  = '0;
      sck_q  = cfg_mirror.clock_polarity;
   endfunction

   function automatic logic outgoing_bit();
      return cfg_mirror.low_bit_first ? shift_q[0] : shift_q[DW-1];
   endfunction

   function automatic void shift_bit_in(logic b);
      if (cfg_mirror.low_bit_first) shift_q = {b, shift_q[DW-1:1]};
      else shift_q = {shift_q[DW-2:0], b};
   endfunction

   // One serial clock edge; returns 1 when the byte completes on it.
   function automatic logic take_edge(logic leading, logic pin);
      if (!cfg_mirror.clock_phase) begin
         if (leading) begin
            sample_q = pin;
         end else begin
            shift_bit_in(sample_q);
            bits_q++;
         end
      end else begin
         if (leading) begin
            if (bits_q > 0) shift_bit_in(sample_q);
         end else begin
            sample_q = pin;
            bits_q++;
            if (bits_q >= DW) shift_bit_in(sample_q);
         end
      end
      if (bits_q >= DW) begin
         rx_q   = shift_q;
         bits_q = '0;
         div_q  = '0;
         busy_q = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic spi_view_type advance_spi(spi_tick_type t);
      spi_view_type v;
      logic         done;
      logic [2:0]   code;
      logic [7:0]   half;
      v = '0;
      done = 1'b0;
      if (!cfg_mirror.enable) begin
         abort_spi();
      end else if (cfg_mirror.master_mode) begin
         if (!busy_q) begin
            sck_q = cfg_mirror.clock_polarity;
            div_q = '0;
            if (t.kind) begin
               shift_q = t.tx;
               busy_q  = 1'b1;
               bits_q  = '0;
            end
         end else begin
            code = (cfg_mirror.clock_divide_select > spi_mst_pkg::DIV_CODE_MAX) ?
                   spi_mst_pkg::DIV_CODE_MAX : cfg_mirror.clock_divide_select;
            half = 8'd1 << code;
            div_q = div_q + 1'b1;
            if ({1'b0, div_q} >= half) begin
               div_q = '0;
               sck_q = ~sck_q;
               done  = take_edge(sck_q != cfg_mirror.clock_polarity, t.miso);
            end
         end
         v.sck_out  = sck_q;
         v.mosi_out = outgoing_bit();
      end else begin
         if (t.kind && !busy_q) shift_q = t.tx;
         if (t.sel_n) begin
            bits_q = '0;
            busy_q = 1'b0;
         end else begin
            if (t.sck != last_sck_q) begin
               busy_q = 1'b1;
               done   = take_edge(t.sck != cfg_mirror.clock_polarity, t.mosi);
            end
            v.miso_out = outgoing_bit();
         end
      end
      last_sck_q = t.sck;
      v.rx   = rx_q;
      v.done = done;
      v.busy = busy_q;
      v.irq  = done & cfg_mirror.interrupt_enable;
      return v;
   endfunction

   // A changed enable or mode drops the transfer; other registers act at once.
   function automatic void apply_csr(logic [2:0] idx, logic [CSR_W-1:0] value);
      case (idx)
         spi_mst_pkg::REG_ENABLE: begin
            if (value[0] != cfg_mirror.enable) begin
               cfg_mirror.enable = value[0];
               abort_spi();
            end
         end
         spi_mst_pkg::REG_MASTER: begin
            if (value[0] != cfg_mirror.master_mode) begin
               cfg_mirror.master_mode = value[0];
               abort_spi();
            end
         end
         spi_mst_pkg::REG_DIVIDE:     cfg_mirror.clock_divide_select = value[2:0];
         spi_mst_pkg::REG_POLARITY:   cfg_mirror.clock_polarity = value[0];
         spi_mst_pkg::REG_PHASE:      cfg_mirror.clock_phase = value[0];
         spi_mst_pkg::REG_LOW_FIRST:  cfg_mirror.low_bit_first = value[0];
         spi_mst_pkg::REG_IRQ_ENABLE: cfg_mirror.interrupt_enable = value[0];
         default: ;
      endcase
   endfunction

   function automatic script_row_type tick_row(logic kind, logic [DW-1:0] tx, logic miso,
                                               logic mosi, logic sck, logic sel_n);
      script_row_type r;
      r = '0;
      r.what = ROW_TICK;
      r.tick = '{kind, tx, miso, mosi, sck, sel_n};
      return r;
   endfunction

   function automatic script_row_type pinned_row(script_row_type r, spi_view_type want);
      r.what   = ROW_PINNED;
      r.pinned = want;
      return r;
   endfunction

   function automatic script_row_type csr_row(logic [2:0] idx, logic [2:0] value);
      script_row_type r;
      r = '0;
      r.what      = ROW_CSR;
      r.reg_idx   = idx;
      r.reg_value = value;
      return r;
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [CSR_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_csr(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_views.size() != 0) @(posedge clock);
   endtask

   task automatic hold_off(input logic steady);
      int unsigned n;
      int unsigned r;
      n = 0;
      r = $urandom_range(0, 19);
      if (!steady) begin
         if (r == 19) n = $urandom_range(15, 40);
         else if (r == 18) n = $urandom_range(4, 8);
         else if (r >= 13) n = $urandom_range(1, 3);
      end
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_tick(input spi_tick_type t, input logic use_pinned,
                            input spi_view_type pinned);
      spi_view_type want;
      req_valid    <= 1'b1;
      req_kind     <= t.kind;
      req_tx_byte  <= t.tx;
      req_miso_in  <= t.miso;
      req_mosi_in  <= t.mosi;
      req_sck_in   <= t.sck;
      req_select_n <= t.sel_n;
      do @(posedge clock); while (!req_ready);
      sent_items++;
      want = advance_spi(t);
      awaited_views.push_back(use_pinned ? pinned : want);
   endtask

   // Result side: stretches of steady readiness mixed with short and long stalls.
   initial begin : result_pacing
      int unsigned r;
      int unsigned span;
      rsp_ready <= 1'b0;
      forever begin
         r = $urandom_range(0, 19);
         if (r < 10) begin
            rsp_ready <= 1'b1;
            span = $urandom_range(1, 40);
         end else begin
            rsp_ready <= 1'b0;
            if (r < 16) span = $urandom_range(1, 3);
            else if (r < 19) span = $urandom_range(4, 10);
            else span = $urandom_range(20, 60);
         end
         repeat (span) @(posedge clock);
      end
   end

   always @(posedge clock) begin : result_check
      spi_view_type got;
      spi_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_sck_out, rsp_mosi_out, rsp_miso_out, rsp_rx_byte,
                 rsp_done_res, rsp_busy_res, rsp_irq};
         if (awaited_views.size() == 0) begin
            log_fault($sformatf("unexpected result transaction: %s", show_view(got)));
         end else begin
            want = awaited_views.pop_front();
            if (got !== want)
               log_fault($sformatf("result mismatch: expected %s, got %s",
                                   show_view(want), show_view(got)));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pwrite && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("spi_master_slave_byte_transceiver verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      script_row_type script [SCRIPT_ROWS];
      spi_tick_type   t;
      int unsigned    phase;
      int unsigned    span;
      int unsigned    i;
      int unsigned    r;
      int unsigned    edges_left;
      int unsigned    hold;
      logic           slave_sel;
      logic           ext_sck;
      logic           steady;
      logic           en;
      logic           ms;
      logic [2:0]     code;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_kind     <= 1'b0;
      req_tx_byte  <= '0;
      req_miso_in  <= 1'b0;
      req_mosi_in  <= 1'b0;
      req_sck_in   <= 1'b0;
      req_select_n <= 1'b1;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;

      cfg_mirror = '{enable: 1'b0, master_mode: 1'b0,
                     clock_divide_select: spi_mst_pkg::DIV_CODE_RESET,
                     clock_polarity: 1'b0, clock_phase: 1'b0, low_bit_first: 1'b0,
                     interrupt_enable: 1'b0};
      shift_q    = '0;
      bits_q     = '0;
      div_q      = '0;
      sck_q      = 1'b0;
      last_sck_q = 1'b0;
      busy_q     = 1'b0;
      rx_q       = '0;
      sample_q   = 1'b0;

      script = '{
         // Disabled after reset: every output stays low, a load is ignored.
         pinned_row(tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
                    spi_view_type'{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}),
         pinned_row(tick_row(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0),
                    spi_view_type'{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}),
         pinned_row(tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
                    spi_view_type'{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0}),
         csr_row(spi_mst_pkg::REG_ENABLE, 3'd1),
         // Slave: load while deselected, a few edges, a load while busy, then deselect.
         tick_row(1'b1, 8'hA5, 1'b0, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0),
         tick_row(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0),
         tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0),
         tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0),
         tick_row(1'b1, 8'h3C, 1'b0, 1'b1, 1'b1, 1'b0),
         tick_row(1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0),
         tick_row(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1),
         csr_row(spi_mst_pkg::REG_MASTER, 3'd1),
         csr_row(spi_mst_pkg::REG_DIVIDE, 3'd0),
         // Master: select is ignored, and a second load during the transfer is dropped.
         tick_row(1'b1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1),
         tick_row(1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0),
         tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
         tick_row(1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b1),
         csr_row(spi_mst_pkg::REG_DIVIDE, DIV_CODE_OVER),
         tick_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1),
         csr_row(spi_mst_pkg::REG_ENABLE, 3'd0),
         tick_row(1'b1, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < SCRIPT_ROWS; i++) begin
         if (script[i].what == ROW_CSR) begin
            drain_results();
            write_csr(script[i].reg_idx, CSR_W'(script[i].reg_value));
         end else begin
            hold_off(1'b0);
            send_tick(script[i].tick, script[i].what == ROW_PINNED, script[i].pinned);
         end
      end

      // Random phases: the first is a slave, the next two pin the slowest master divider.
      for (phase = 0; sent_items < ITEM_TARGET; phase++) begin
         drain_results();
         if (phase == 0) begin
            en = 1'b1; ms = 1'b0; code = 3'd0;
         end else if (phase == 1) begin
            en = 1'b1; ms = 1'b1; code = spi_mst_pkg::DIV_CODE_MAX;
         end else if (phase == 2) begin
            en = 1'b1; ms = 1'b1; code = DIV_CODE_OVER;
         end else begin
            en = ($urandom_range(0, 7) != 0);
            ms = 1'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r < 5) code = 3'd0;
            else if (r < 8) code = 3'($urandom_range(1, 2));
            else code = 3'($urandom_range(3, 5));
         end
         write_csr(spi_mst_pkg::REG_ENABLE, CSR_W'(en));
         write_csr(spi_mst_pkg::REG_MASTER, CSR_W'(ms));
         write_csr(spi_mst_pkg::REG_DIVIDE, CSR_W'(code));
         write_csr(spi_mst_pkg::REG_POLARITY, CSR_W'($urandom_range(0, 1)));
         write_csr(spi_mst_pkg::REG_PHASE, CSR_W'($urandom_range(0, 1)));
         write_csr(spi_mst_pkg::REG_LOW_FIRST, CSR_W'($urandom_range(0, 1)));
         write_csr(spi_mst_pkg::REG_IRQ_ENABLE, CSR_W'($urandom_range(0, 1)));

         span       = (code >= 3'd5) ? 140 : $urandom_range(25, 70);
         steady     = ($urandom_range(0, 3) == 0);
         slave_sel  = 1'b0;
         edges_left = 0;
         hold       = 0;
         ext_sck    = cfg_mirror.clock_polarity;

         for (i = 0; i < span && sent_items < ITEM_TARGET; i++) begin
            t.kind  = 1'($urandom_range(0, 1));
            t.tx    = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                                  : 8'($urandom());
            t.miso  = 1'($urandom_range(0, 1));
            t.mosi  = 1'($urandom_range(0, 1));
            t.sck   = 1'($urandom_range(0, 1));
            t.sel_n = 1'($urandom_range(0, 1));
            if (cfg_mirror.enable && cfg_mirror.master_mode) begin
               // Reload soon after each byte; a rare load mid-transfer must be ignored.
               t.kind = busy_q ? ($urandom_range(0, 15) == 0) : ($urandom_range(0, 4) != 0);
            end else if (cfg_mirror.enable) begin
               if (!slave_sel) begin
                  ext_sck = cfg_mirror.clock_polarity;
                  t.sel_n = 1'b1;
                  if ($urandom_range(0, 2) == 0) begin
                     slave_sel = 1'b1;
                     r = $urandom_range(0, 7);
                     if (r == 0) edges_left = $urandom_range(1, 15);
                     else if (r == 1) edges_left = 32;
                     else edges_left = 16;
                     hold = $urandom_range(0, 2);
                  end
               end else begin
                  t.sel_n = 1'b0;
                  t.kind  = ($urandom_range(0, 7) == 0);
                  if (edges_left == 0) begin
                     slave_sel = 1'b0;
                  end else if (hold != 0) begin
                     hold--;
                  end else begin
                     ext_sck = ~ext_sck;
                     edges_left--;
                     hold = $urandom_range(0, 2);
                  end
               end
               t.sck = ext_sck;
            end
            hold_off(steady);
            send_tick(t, 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_views.size() == 0) begin
         $display("spi_master_slave_byte_transceiver verification clean");
      end else begin
         $display("spi_master_slave_byte_transceiver verification failed");
      end
      $finish;
   end

endmodule
